@@ design/vote_consent_coordinator_assert.svh @@
// Assertion macros used by the coordinator engine RTL.
`ifndef VOTE_CONSENT_COORDINATOR_ASSERT_SVH
`define VOTE_CONSENT_COORDINATOR_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define VCC_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("vcc assertion failed");

// Next-cycle implication, checked outside reset.
`define VCC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("vcc assertion failed");

`endif

@@ design/vcc_pkg.sv @@
package vcc_pkg;

   localparam int MAX_VOTERS = 16;
   localparam int TIME_W     = 32;
   localparam int RETRY_W    = 16;
   localparam int TALLY_W    = 5;
   localparam int ID_W       = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [2:0] {
      CMD_START  = 3'd0,
      CMD_FORCE  = 3'd1,
      CMD_CANCEL = 3'd2,
      CMD_VOTE   = 3'd3,
      CMD_TICK   = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      VOTE_MISSING = 2'd0,
      VOTE_ALLOW   = 2'd1,
      VOTE_REJECT  = 2'd2,
      VOTE_DEFER   = 2'd3
   } vote_type;

   typedef enum logic [2:0] {
      EV_NONE   = 3'd0,
      EV_GRANT  = 3'd1,
      EV_REJECT = 3'd2,
      EV_DEFER  = 3'd3,
      EV_FAIL   = 3'd4,
      EV_CANCEL = 3'd5
   } event_type;

   typedef enum logic [2:0] {
      ER_NONE     = 3'd0,
      ER_ACTIVE   = 3'd1,
      ER_NOVOTERS = 3'd2,
      ER_TIMEOUT  = 3'd3,
      ER_RETRY    = 3'd4,
      ER_MISSING  = 3'd5,
      ER_CANCEL   = 3'd6,
      ER_NOTCOLL  = 3'd7
   } error_type;

   typedef enum logic [2:0] {
      PH_IDLE    = 3'd0,
      PH_COLLECT = 3'd1,
      PH_DEFER   = 3'd2,
      PH_GRANT   = 3'd3,
      PH_REJECT  = 3'd4,
      PH_FAIL    = 3'd5,
      PH_CANCEL  = 3'd6
   } phase_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_VOTER_COUNT   = 3'd0,
      REG_ALLOW_NO_VOTE = 3'd1,
      REG_TIMEOUT       = 3'd2,
      REG_MAX_RETRIES   = 3'd3,
      REG_MIN_DEFER     = 3'd4,
      REG_DEFAULT_DEFER = 3'd5,
      REG_MAX_DEFER     = 3'd6
   } reg_index_type;

   typedef struct packed {
      logic [TALLY_W-1:0] voter_count;
      logic               allow_without_voters;
      logic [TIME_W-1:0]  timeout_ms;
      logic [RETRY_W-1:0] max_retries;
      logic [TIME_W-1:0]  min_defer_ms;
      logic [TIME_W-1:0]  default_defer_ms;
      logic [TIME_W-1:0]  max_defer_ms;
   } cfg_type;

   // Registered command; the defer time is already clamped.
   typedef struct packed {
      cmd_type           cmd;
      vote_type          kind;
      logic [TIME_W-1:0] defer_ms;
   } item_type;

   typedef struct packed {
      event_type          event_res;
      error_type          error_code;
      phase_type          phase;
      logic [RETRY_W-1:0] retry_count;
      logic [TIME_W-1:0]  retry_after_ms;
      logic [TALLY_W-1:0] allow_votes;
      logic [TALLY_W-1:0] reject_votes;
      logic [TALLY_W-1:0] defer_votes;
      logic [ID_W-1:0]    request_number;
   } result_type;

   // Request identifiers wrap but never take the value zero.
   function automatic logic [ID_W-1:0] next_id(input logic [ID_W-1:0] v);
      return (v == '1) ? ID_W'(1) : v + ID_W'(1);
   endfunction

   function automatic logic [TALLY_W-1:0] sat_inc(input logic [TALLY_W-1:0] t);
      return (t == '1) ? t : t + TALLY_W'(1);
   endfunction

endpackage

@@ design/vcc_csr.sv @@
module vcc_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [vcc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [vcc_pkg::CSR_DATA_W-1:0]   csr_data,
   output vcc_pkg::cfg_type                 cfg
);

   vcc_pkg::cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (vcc_pkg::reg_index_type'(csr_index))
            vcc_pkg::REG_VOTER_COUNT:
               cfg_in.voter_count = csr_data[vcc_pkg::TALLY_W-1:0];
            vcc_pkg::REG_ALLOW_NO_VOTE: cfg_in.allow_without_voters = csr_data[0];
            vcc_pkg::REG_TIMEOUT:       cfg_in.timeout_ms = csr_data[vcc_pkg::TIME_W-1:0];
            vcc_pkg::REG_MAX_RETRIES:
               cfg_in.max_retries = csr_data[vcc_pkg::RETRY_W-1:0];
            vcc_pkg::REG_MIN_DEFER:     cfg_in.min_defer_ms = csr_data[vcc_pkg::TIME_W-1:0];
            vcc_pkg::REG_DEFAULT_DEFER:
               cfg_in.default_defer_ms = csr_data[vcc_pkg::TIME_W-1:0];
            vcc_pkg::REG_MAX_DEFER:     cfg_in.max_defer_ms = csr_data[vcc_pkg::TIME_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.voter_count          <= '0;
         cfg_ff.allow_without_voters <= 1'b0;
         cfg_ff.timeout_ms           <= '0;
         cfg_ff.max_retries          <= vcc_pkg::RETRY_W'(3);
         cfg_ff.min_defer_ms         <= vcc_pkg::TIME_W'(100);
         cfg_ff.default_defer_ms     <= vcc_pkg::TIME_W'(1000);
         cfg_ff.max_defer_ms         <= vcc_pkg::TIME_W'(60000);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ design/vcc_intake.sv @@
module vcc_intake (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [2:0]                    req_cmd,
   input  logic [1:0]                    req_vote_kind,
   input  logic [vcc_pkg::TIME_W-1:0]    req_defer_ms,
   input  vcc_pkg::cfg_type              cfg,
   input  logic                          take,
   output logic                          item_valid,
   output vcc_pkg::item_type             item
);

   logic                      valid_ff, valid_in;
   vcc_pkg::item_type         item_ff, item_in;
   logic [vcc_pkg::TIME_W-1:0] clamp;
   logic                      load;

   // Clamp at capture: zero takes the default, then min, then max wins.
   always_comb begin
      clamp = (req_defer_ms == '0) ? cfg.default_defer_ms : req_defer_ms;
      if (clamp < cfg.min_defer_ms) begin
         clamp = cfg.min_defer_ms;
      end
      if (clamp > cfg.max_defer_ms) begin
         clamp = cfg.max_defer_ms;
      end
   end

   assign req_ready = !valid_ff || take;
   assign load      = req_valid && req_ready;

   always_comb begin
      item_in.cmd      = vcc_pkg::cmd_type'(req_cmd);
      item_in.kind     = vcc_pkg::vote_type'(req_vote_kind);
      item_in.defer_ms = clamp;
      valid_in         = load || (valid_ff && !take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= item_in;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

@@ design/vcc_engine.sv @@
module vcc_engine (
   input  logic                 clock,
   input  logic                 reset,
   input  vcc_pkg::cfg_type     cfg,
   input  logic                 item_valid,
   input  vcc_pkg::item_type    item,
   output logic                 take,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output vcc_pkg::result_type  rsp
);

   `include "vote_consent_coordinator_assert.svh"

   vcc_pkg::phase_type              phase_ff, phase_in;
   logic [vcc_pkg::TIME_W-1:0]      now_ff, now_in;
   logic [vcc_pkg::TIME_W-1:0]      start_ff, start_in;
   logic [vcc_pkg::TIME_W-1:0]      due_ff, due_in;
   logic [vcc_pkg::TIME_W-1:0]      dmax_ff, dmax_in;
   logic [vcc_pkg::RETRY_W-1:0]     retries_ff, retries_in;
   logic [vcc_pkg::TALLY_W-1:0]     seen_ff, seen_in;
   logic [vcc_pkg::TALLY_W-1:0]     allow_ff, allow_in;
   logic [vcc_pkg::TALLY_W-1:0]     rej_ff, rej_in;
   logic [vcc_pkg::TALLY_W-1:0]     defer_ff, defer_in;
   logic [vcc_pkg::ID_W-1:0]        ctr_ff, ctr_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   vcc_pkg::result_type             rsp_ff, rsp_in;

   // Working values after the command, before a finish clears them.
   vcc_pkg::phase_type              ph_w;
   logic [vcc_pkg::TIME_W-1:0]      start_w, due_w, dmax_w, elapsed, since_due;
   logic [vcc_pkg::RETRY_W-1:0]     retries_w;
   logic [vcc_pkg::TALLY_W-1:0]     seen_w, allow_w, rej_w, defer_w, voters;
   logic [vcc_pkg::ID_W-1:0]        ctr_w;
   logic                            active, begin_rnd, fin;
   vcc_pkg::phase_type              fin_ph;
   vcc_pkg::event_type              ev;
   vcc_pkg::error_type              err;

   assign take   = item_valid && (!rsp_valid_ff || rsp_ready);
   assign active = (phase_ff == vcc_pkg::PH_COLLECT) || (phase_ff == vcc_pkg::PH_DEFER);
   assign voters = (32'(cfg.voter_count) > vcc_pkg::MAX_VOTERS) ?
                   vcc_pkg::TALLY_W'(vcc_pkg::MAX_VOTERS) : cfg.voter_count;

   // Next state
   always_comb begin
      ph_w      = phase_ff;
      now_in    = now_ff;
      start_w   = start_ff;
      due_w     = due_ff;
      dmax_w    = dmax_ff;
      retries_w = retries_ff;
      seen_w    = seen_ff;
      allow_w   = allow_ff;
      rej_w     = rej_ff;
      defer_w   = defer_ff;
      ctr_w     = ctr_ff;
      begin_rnd = 1'b0;
      fin       = 1'b0;
      fin_ph    = vcc_pkg::PH_IDLE;
      ev        = vcc_pkg::EV_NONE;
      err       = vcc_pkg::ER_NONE;
      elapsed   = now_ff + vcc_pkg::TIME_W'(1) - start_ff;
      since_due = now_ff + vcc_pkg::TIME_W'(1) - due_ff;

      unique case (item.cmd) inside
         vcc_pkg::CMD_START, vcc_pkg::CMD_FORCE: begin
            if (active) begin
               err = vcc_pkg::ER_ACTIVE;
            end else begin
               ctr_w     = vcc_pkg::next_id(ctr_ff);
               due_w     = '0;
               dmax_w    = '0;
               retries_w = '0;
               seen_w    = '0;
               allow_w   = '0;
               rej_w     = '0;
               defer_w   = '0;
               if (item.cmd == vcc_pkg::CMD_START) begin
                  ph_w      = vcc_pkg::PH_COLLECT;
                  start_w   = now_ff;
                  begin_rnd = 1'b1;
               end else begin
                  start_w = '0;
                  fin     = 1'b1;
                  fin_ph  = vcc_pkg::PH_GRANT;
                  ev      = vcc_pkg::EV_GRANT;
               end
            end
         end
         vcc_pkg::CMD_CANCEL: begin
            if (active) begin
               fin    = 1'b1;
               fin_ph = vcc_pkg::PH_CANCEL;
               ev     = vcc_pkg::EV_CANCEL;
               err    = vcc_pkg::ER_CANCEL;
            end
         end
         vcc_pkg::CMD_VOTE: begin
            if (phase_ff != vcc_pkg::PH_COLLECT) begin
               err = vcc_pkg::ER_NOTCOLL;
            end else if (item.kind == vcc_pkg::VOTE_MISSING) begin
               fin    = 1'b1;
               fin_ph = vcc_pkg::PH_FAIL;
               ev     = vcc_pkg::EV_FAIL;
               err    = vcc_pkg::ER_MISSING;
            end else begin
               case (item.kind)
                  vcc_pkg::VOTE_ALLOW:  allow_w = vcc_pkg::sat_inc(allow_ff);
                  vcc_pkg::VOTE_REJECT: rej_w   = vcc_pkg::sat_inc(rej_ff);
                  default: begin
                     defer_w = vcc_pkg::sat_inc(defer_ff);
                     if (item.defer_ms > dmax_ff) begin
                        dmax_w = item.defer_ms;
                     end
                  end
               endcase
               seen_w = vcc_pkg::sat_inc(seen_ff);
               // round judged once every expected vote is in
               if (seen_w >= voters) begin
                  if (rej_w != '0) begin
                     fin    = 1'b1;
                     fin_ph = vcc_pkg::PH_REJECT;
                     ev     = vcc_pkg::EV_REJECT;
                  end else if (defer_w != '0) begin
                     if (retries_ff >= cfg.max_retries) begin
                        fin    = 1'b1;
                        fin_ph = vcc_pkg::PH_FAIL;
                        ev     = vcc_pkg::EV_FAIL;
                        err    = vcc_pkg::ER_RETRY;
                     end else begin
                        retries_w = retries_ff + vcc_pkg::RETRY_W'(1);
                        ph_w      = vcc_pkg::PH_DEFER;
                        due_w     = now_ff + dmax_w;
                        ev        = vcc_pkg::EV_DEFER;
                     end
                  end else begin
                     fin    = 1'b1;
                     fin_ph = vcc_pkg::PH_GRANT;
                     ev     = vcc_pkg::EV_GRANT;
                  end
               end
            end
         end
         vcc_pkg::CMD_TICK: begin
            now_in = now_ff + vcc_pkg::TIME_W'(1);
            if (active) begin
               if ((cfg.timeout_ms != '0) && (elapsed >= cfg.timeout_ms)) begin
                  fin    = 1'b1;
                  fin_ph = vcc_pkg::PH_FAIL;
                  ev     = vcc_pkg::EV_FAIL;
                  err    = vcc_pkg::ER_TIMEOUT;
               end else if ((phase_ff == vcc_pkg::PH_DEFER) &&
                            !since_due[vcc_pkg::TIME_W-1]) begin
                  ph_w      = vcc_pkg::PH_COLLECT;
                  begin_rnd = 1'b1;
               end
            end
         end
         default: ;
      endcase

      // new round: zero voters settles it at once
      if (begin_rnd) begin
         if (voters == '0) begin
            fin = 1'b1;
            if (cfg.allow_without_voters) begin
               fin_ph = vcc_pkg::PH_GRANT;
               ev     = vcc_pkg::EV_GRANT;
            end else begin
               fin_ph = vcc_pkg::PH_FAIL;
               ev     = vcc_pkg::EV_FAIL;
               err    = vcc_pkg::ER_NOVOTERS;
            end
         end else begin
            seen_w  = '0;
            allow_w = '0;
            rej_w   = '0;
            defer_w = '0;
            dmax_w  = '0;
         end
      end

      if (fin) begin
         phase_in   = fin_ph;
         ctr_in     = vcc_pkg::next_id(ctr_w);
         start_in   = '0;
         due_in     = '0;
         dmax_in    = '0;
         retries_in = '0;
         seen_in    = '0;
         allow_in   = '0;
         rej_in     = '0;
         defer_in   = '0;
      end else begin
         phase_in   = ph_w;
         ctr_in     = ctr_w;
         start_in   = start_w;
         due_in     = due_w;
         dmax_in    = dmax_w;
         retries_in = retries_w;
         seen_in    = seen_w;
         allow_in   = allow_w;
         rej_in     = rej_w;
         defer_in   = defer_w;
      end
   end

   // Outputs: values seen just before any clearing
   always_comb begin
      rsp_in.event_res      = ev;
      rsp_in.error_code     = err;
      rsp_in.phase          = fin ? fin_ph : ph_w;
      rsp_in.retry_count    = retries_w;
      rsp_in.retry_after_ms = dmax_w;
      rsp_in.allow_votes    = allow_w;
      rsp_in.reject_votes   = rej_w;
      rsp_in.defer_votes    = defer_w;
      rsp_in.request_number = ctr_w;
      rsp_valid_in          = take || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= vcc_pkg::PH_IDLE;
         now_ff       <= '0;
         start_ff     <= '0;
         due_ff       <= '0;
         dmax_ff      <= '0;
         retries_ff   <= '0;
         seen_ff      <= '0;
         allow_ff     <= '0;
         rej_ff       <= '0;
         defer_ff     <= '0;
         ctr_ff       <= vcc_pkg::ID_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (take) begin
            phase_ff   <= phase_in;
            now_ff     <= now_in;
            start_ff   <= start_in;
            due_ff     <= due_in;
            dmax_ff    <= dmax_in;
            retries_ff <= retries_in;
            seen_ff    <= seen_in;
            allow_ff   <= allow_in;
            rej_ff     <= rej_in;
            defer_ff   <= defer_in;
            ctr_ff     <= ctr_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   `VCC_ASSERT_IMPL(a_id_nonzero, clock, reset, 1'b1, ctr_ff != '0)
   `VCC_ASSERT_IMPL(a_idle_clear, clock, reset, !active,
      (allow_ff == '0) && (rej_ff == '0) && (defer_ff == '0) && (retries_ff == '0))
   `VCC_ASSERT_NEXT(a_final_closes, clock, reset,
      take && fin, !((phase_ff == vcc_pkg::PH_COLLECT) || (phase_ff == vcc_pkg::PH_DEFER)))
   `VCC_ASSERT_NEXT(a_defer_waits, clock, reset,
      take && (ev == vcc_pkg::EV_DEFER), phase_ff == vcc_pkg::PH_DEFER)

endmodule

@@ design/vote_consent_coordinator.sv @@
// Channel  | Ports                                   | Direction | Moves
// ---------+-----------------------------------------+-----------+-----------------------------
// req      | req_valid/ready, cmd, vote_kind, defer  | in        | one command transaction
// rsp      | rsp_valid/ready, event .. request_number| out       | one result per command
// csr      | csr_valid/ready, csr_index, csr_data    | in        | one register write
//
// From req acceptance to rsp_valid, the input register captures at the accepting
// edge (defer clamp done on capture) and the result register loads when the
// engine takes the item. Throughput is one transaction per cycle while rsp is
// not stalled; vcc_engine updates all request state as it takes each item.
// Reset (synchronous, active high) empties both stages and loads register
// defaults. A stalled rsp holds the result; req keeps flowing while the input
// register can drain into the free result register.
module vote_consent_coordinator (
   input  logic                           clock,
   input  logic                           reset,
   // command channel
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [2:0]                     req_cmd,
   input  logic [1:0]                     req_vote_kind,
   input  logic [31:0]                    req_defer_ms,
   // result channel
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [2:0]                     rsp_event_res,
   output logic [2:0]                     rsp_error_code,
   output logic [2:0]                     rsp_phase,
   output logic [15:0]                    rsp_retry_count,
   output logic [31:0]                    rsp_retry_after_ms,
   output logic [4:0]                     rsp_allow_votes,
   output logic [4:0]                     rsp_reject_votes,
   output logic [4:0]                     rsp_defer_votes,
   output logic [31:0]                    rsp_request_number,
   // register writes
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [vcc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [vcc_pkg::CSR_DATA_W-1:0] csr_data
);

   vcc_pkg::cfg_type    cfg;
   vcc_pkg::item_type   item;
   vcc_pkg::result_type rsp;
   logic                item_valid;
   logic                take;

   // configuration registers
   vcc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // input register; the defer time is clamped against the live config here
   vcc_intake u_intake (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_cmd       (req_cmd),
      .req_vote_kind (req_vote_kind),
      .req_defer_ms  (req_defer_ms),
      .cfg           (cfg),
      .take          (take),
      .item_valid    (item_valid),
      .item          (item)
   );

   // request state, round judging and the result register
   vcc_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .item_valid (item_valid),
      .item       (item),
      .take       (take),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp        (rsp)
   );

   assign rsp_event_res      = rsp.event_res;
   assign rsp_error_code     = rsp.error_code;
   assign rsp_phase          = rsp.phase;
   assign rsp_retry_count    = rsp.retry_count;
   assign rsp_retry_after_ms = rsp.retry_after_ms;
   assign rsp_allow_votes    = rsp.allow_votes;
   assign rsp_reject_votes   = rsp.reject_votes;
   assign rsp_defer_votes    = rsp.defer_votes;
   assign rsp_request_number = rsp.request_number;

endmodule
